// ===== hw/rtl/hx_pkg.sv =====
// ----------------------------------------------------------------------------
// hx_pkg: shared types and constants of the harmonic exciter
// Register indexes, sequencer states and the serial multiplier geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package hx_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 26;

    localparam logic [CFG_IW-1:0] REG_INTENSITY = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MIX       = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COEF_B0   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_COEF_B1   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_COEF_B2   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_COEF_A1   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_COEF_A2   = 3'd6;

    localparam int MUL_AW     = 48;
    localparam int MUL_BW     = 28;
    localparam int MUL_DW     = 4;
    localparam int MUL_DIGITS = MUL_BW / MUL_DW;
    localparam int MUL_PW     = MUL_AW + MUL_BW;
    localparam int MUL_CW     = $clog2(MUL_DIGITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B0X,
        ST_B1X,
        ST_A1Y,
        ST_B2X,
        ST_A2Y,
        ST_UY,
        ST_POS,
        ST_RDLO,
        ST_RDHI,
        ST_RDWT,
        ST_FR,
        ST_DRY,
        ST_WET,
        ST_OUT
    } hx_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/harmonic_exciter.sv =====
// ----------------------------------------------------------------------------
// harmonic_exciter: high-pass filter, drive and tanh saturation with dry/wet mix
// Per-channel biquad high-pass, tanh table with interpolation, rounded mix.
// ----------------------------------------------------------------------------
// One sample is processed at a time, and the next is taken only after the
// result has moved to the output register. The processing time is set by
// the single shared multiplier, which takes one 4-bit digit per cycle for
// each of the ten products of a sample (eight when the driven value reaches
// the tanh clamp); the table read passes through the RDLO, RDHI and RDWT
// states. A finished result waits in the output register while the next
// sample is taken in. Filter state is cleared at reset.
`default_nettype none

module harmonic_exciter #(
    parameter int CHANNELS     = 2,
    parameter int TANH_ENTRIES = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hx_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [hx_pkg::CFG_DW-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_channel,
    input  wire logic signed [23:0]            s_sample_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [23:0]                 m_sample_out,
    output logic                               m_out_channel
);

    localparam int SW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = $clog2(TANH_ENTRIES + 1);
    localparam int PW = hx_pkg::MUL_PW;

    function automatic logic signed [PW-1:0] clamp(input logic signed [PW-1:0] v,
                                                   input int w);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = (PW'(1) <<< (w - 1)) - PW'(1);
        lo = -hi - PW'(1);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    hx_pkg::hx_state_t state_reg, state_next;
    logic launched_reg, launched_next;

    logic [16:0]        intensity_reg;
    logic [16:0]        mix_reg;
    logic signed [25:0] coef_b0_reg;
    logic signed [25:0] coef_b1_reg;
    logic signed [25:0] coef_b2_reg;
    logic signed [25:0] coef_a1_reg;
    logic signed [25:0] coef_a2_reg;

    logic signed [47:0] fs1_reg [CHANNELS];
    logic signed [47:0] fs2_reg [CHANNELS];

    logic signed [23:0] x_reg;
    logic               ch_reg;
    logic [SW-1:0]      slot_reg;
    logic signed [47:0] s1_reg;
    logic signed [47:0] s2_reg;
    logic signed [25:0] y_reg;
    logic signed [53:0] t_reg;
    logic signed [47:0] ns1_reg;
    logic               u_neg_reg;
    logic [40:0]        mag_reg;
    logic [AW-1:0]      idx_reg;
    logic [19:0]        f_reg;
    logic [23:0]        lo_reg;
    logic [23:0]        hi_reg;
    logic signed [24:0] tv_reg;
    logic signed [23:0] res_reg;

    logic               m_valid_reg;
    logic signed [23:0] m_sample_reg;
    logic               m_channel_reg;

    logic                               mul_start;
    logic                               mul_done;
    logic signed [hx_pkg::MUL_AW-1:0]   mul_a;
    logic signed [hx_pkg::MUL_BW-1:0]   mul_b;
    logic signed [PW-1:0]               mul_p;

    logic [AW-1:0]      rom_addr;
    logic [23:0]        rom_data;

    logic [SW-1:0]      slot_in;
    logic [16:0]        inten_c;
    logic [16:0]        mix_c;
    logic [16:0]        dry_w;
    logic [18:0]        drive;
    logic signed [24:0] diff;
    logic signed [24:0] wet;
    logic [PW-1:0]      mag_full;
    logic               big_now;
    logic               out_free;

    logic signed [25:0] y_next;
    logic signed [47:0] ns1_next;
    logic signed [47:0] ns2_next;
    logic signed [24:0] tv_next;
    logic signed [23:0] res_next;

    assign slot_in  = (CHANNELS > 1) ? SW'(s_channel) : SW'(0);
    assign inten_c  = (intensity_reg > 17'd65536) ? 17'd65536 : intensity_reg;
    assign mix_c    = (mix_reg > 17'd65536) ? 17'd65536 : mix_reg;
    assign dry_w    = 17'd65536 - mix_c;
    assign drive    = 19'd65536 + {inten_c, 2'b00} + 19'(inten_c);
    assign diff     = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
    assign wet      = u_neg_reg ? -tv_reg : tv_reg;
    assign mag_full = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);
    assign big_now  = |mag_full[44:41];
    assign out_free = !m_valid_reg || m_ready;

    assign y_next   = 26'(clamp((mul_p + PW'(64'sd2097152) + PW'(s1_reg)) >>> 22, 26));
    assign ns1_next = 48'(clamp(PW'(t_reg) - mul_p + PW'(s2_reg), 48));
    assign ns2_next = 48'(clamp(PW'(t_reg) - mul_p, 48));
    assign tv_next  = 25'(PW'($signed({1'b0, lo_reg}))
                          + ((mul_p + PW'(64'sd524288)) >>> 20));
    assign res_next = 24'(clamp((PW'(t_reg) + mul_p + PW'(64'sd32768)) >>> 16, 24));

    assign rom_addr = (state_reg == hx_pkg::ST_RDLO) ? idx_reg : idx_reg + 1'b1;

    hx_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    hx_tanh_rom #(
        .TANH_ENTRIES (TANH_ENTRIES)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hx_pkg::ST_IDLE;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            hx_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next    = hx_pkg::ST_B0X;
                    launched_next = 1'b0;
                end
            end
            hx_pkg::ST_RDLO: state_next = hx_pkg::ST_RDHI;
            hx_pkg::ST_RDHI: state_next = hx_pkg::ST_RDWT;
            hx_pkg::ST_RDWT: state_next = hx_pkg::ST_FR;
            hx_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = hx_pkg::ST_IDLE;
                end
            end
            default: begin
                unique case (state_reg)
                    hx_pkg::ST_B0X: begin
                        mul_a = 48'(x_reg);
                        mul_b = 28'(coef_b0_reg);
                    end
                    hx_pkg::ST_B1X: begin
                        mul_a = 48'(x_reg);
                        mul_b = 28'(coef_b1_reg);
                    end
                    hx_pkg::ST_A1Y: begin
                        mul_a = 48'(y_reg);
                        mul_b = 28'(coef_a1_reg);
                    end
                    hx_pkg::ST_B2X: begin
                        mul_a = 48'(x_reg);
                        mul_b = 28'(coef_b2_reg);
                    end
                    hx_pkg::ST_A2Y: begin
                        mul_a = 48'(y_reg);
                        mul_b = 28'(coef_a2_reg);
                    end
                    hx_pkg::ST_UY: begin
                        mul_a = 48'(y_reg);
                        mul_b = 28'(drive);
                    end
                    hx_pkg::ST_POS: begin
                        mul_a = 48'(mag_reg);
                        mul_b = 28'(TANH_ENTRIES);
                    end
                    hx_pkg::ST_FR: begin
                        mul_a = 48'(diff);
                        mul_b = 28'(f_reg);
                    end
                    hx_pkg::ST_DRY: begin
                        mul_a = 48'(x_reg);
                        mul_b = 28'(dry_w);
                    end
                    default: begin
                        mul_a = 48'(wet);
                        mul_b = 28'(mix_c);
                    end
                endcase
                if (!launched_reg) begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end else if (mul_done) begin
                    launched_next = 1'b0;
                    unique case (state_reg)
                        hx_pkg::ST_B0X: state_next = hx_pkg::ST_B1X;
                        hx_pkg::ST_B1X: state_next = hx_pkg::ST_A1Y;
                        hx_pkg::ST_A1Y: state_next = hx_pkg::ST_B2X;
                        hx_pkg::ST_B2X: state_next = hx_pkg::ST_A2Y;
                        hx_pkg::ST_A2Y: state_next = hx_pkg::ST_UY;
                        hx_pkg::ST_UY:  state_next = big_now ? hx_pkg::ST_DRY
                                                             : hx_pkg::ST_POS;
                        hx_pkg::ST_POS: state_next = hx_pkg::ST_RDLO;
                        hx_pkg::ST_FR:  state_next = hx_pkg::ST_DRY;
                        hx_pkg::ST_DRY: state_next = hx_pkg::ST_WET;
                        default:        state_next = hx_pkg::ST_OUT;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intensity_reg <= '0;
            mix_reg       <= '0;
            coef_b0_reg   <= '0;
            coef_b1_reg   <= '0;
            coef_b2_reg   <= '0;
            coef_a1_reg   <= '0;
            coef_a2_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hx_pkg::REG_INTENSITY: intensity_reg <= cfg_data[16:0];
                hx_pkg::REG_MIX:       mix_reg       <= cfg_data[16:0];
                hx_pkg::REG_COEF_B0:   coef_b0_reg   <= cfg_data;
                hx_pkg::REG_COEF_B1:   coef_b1_reg   <= cfg_data;
                hx_pkg::REG_COEF_B2:   coef_b2_reg   <= cfg_data;
                hx_pkg::REG_COEF_A1:   coef_a1_reg   <= cfg_data;
                hx_pkg::REG_COEF_A2:   coef_a2_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                fs1_reg[c] <= '0;
                fs2_reg[c] <= '0;
            end
        end else if (state_reg == hx_pkg::ST_A2Y && launched_reg && mul_done) begin
            fs1_reg[slot_reg] <= ns1_reg;
            fs2_reg[slot_reg] <= ns2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hx_pkg::ST_IDLE && s_valid) begin
            x_reg    <= s_sample_in;
            ch_reg   <= s_channel;
            slot_reg <= slot_in;
            s1_reg   <= fs1_reg[slot_in];
            s2_reg   <= fs2_reg[slot_in];
        end
        if (state_reg == hx_pkg::ST_RDHI) begin
            lo_reg <= rom_data;
        end
        if (state_reg == hx_pkg::ST_RDWT) begin
            hi_reg <= rom_data;
        end
        if (launched_reg && mul_done) begin
            case (state_reg)
                hx_pkg::ST_B0X: y_reg   <= y_next;
                hx_pkg::ST_B1X: t_reg   <= 54'(mul_p);
                hx_pkg::ST_A1Y: ns1_reg <= ns1_next;
                hx_pkg::ST_B2X: t_reg   <= 54'(mul_p);
                hx_pkg::ST_UY: begin
                    u_neg_reg <= mul_p[PW-1];
                    mag_reg   <= mag_full[40:0];
                    tv_reg    <= 25'sd8388608;
                end
                hx_pkg::ST_POS: begin
                    idx_reg <= mul_p[41 +: AW];
                    f_reg   <= mul_p[40:21];
                end
                hx_pkg::ST_FR:  tv_reg  <= tv_next;
                hx_pkg::ST_DRY: t_reg   <= 54'(mul_p);
                hx_pkg::ST_WET: res_reg <= res_next;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == hx_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hx_pkg::ST_OUT && out_free) begin
            m_sample_reg  <= res_reg;
            m_channel_reg <= ch_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_out_channel = m_channel_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hx_serial_mul.sv =====
// ----------------------------------------------------------------------------
// hx_serial_mul: digit-serial signed multiplier
// Consumes the multiplier operand one 4-bit digit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module hx_serial_mul (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [hx_pkg::MUL_AW-1:0]     a,
    input  wire logic signed [hx_pkg::MUL_BW-1:0]     b,
    output logic                                      done,
    output logic signed [hx_pkg::MUL_PW-1:0]          p
);

    localparam int AW = hx_pkg::MUL_AW;
    localparam int BW = hx_pkg::MUL_BW;
    localparam int DW = hx_pkg::MUL_DW;
    localparam int PW = hx_pkg::MUL_PW;
    localparam int CW = hx_pkg::MUL_CW;

    logic signed [AW-1:0]    a_reg;
    logic        [BW-1:0]    b_reg;
    logic signed [PW-1:0]    acc_reg;
    logic        [CW-1:0]    cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [DW:0]      digit;
    logic signed [AW+DW:0]   part;
    logic signed [PW-1:0]    acc_next;

    assign digit    = (cnt_reg == '0) ? {b_reg[BW-1], b_reg[BW-1 -: DW]}
                                      : {1'b0, b_reg[BW-1 -: DW]};
    assign part     = a_reg * digit;
    assign acc_next = (acc_reg <<< DW) + PW'(part);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(hx_pkg::MUL_DIGITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << DW;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/hx_tanh_rom.sv =====
// ----------------------------------------------------------------------------
// hx_tanh_rom: tanh lookup table over magnitudes 0 to 4
// Unsigned Q.23 entries built at elaboration, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hx_tanh_rom #(
    parameter int TANH_ENTRIES = 1024
) (
    input  wire logic                                  aclk,
    input  wire logic [$clog2(TANH_ENTRIES+1)-1:0]     addr,
    output logic      [23:0]                           data
);

    localparam logic [63:0] ONE = 64'd1 << 32;
    localparam logic [63:0] H   = (64'd1 << 35) / TANH_ENTRIES;

    typedef logic [23:0] tab_t [0:TANH_ENTRIES];

    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mulq32(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] prod;
        prod = x * y;
        return (prod + (64'd1 << 31)) >> 32;
    endfunction

    function automatic tab_t build_tab();
        tab_t        tab;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] pw [0:12];
        logic [63:0] pv;
        logic [63:0] num;
        logic [63:0] den;
        logic [31:0] iv;
        sum  = ONE;
        term = ONE;
        for (int k = 1; k <= 12; k++) begin
            term = udiv(term * H, 64'(k) << 32);
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        pw[0] = sum;
        for (int k = 1; k < 13; k++) begin
            pw[k] = mulq32(pw[k-1], pw[k-1]);
        end
        for (int i = 0; i <= TANH_ENTRIES; i++) begin
            iv = 32'(i);
            pv = ONE;
            for (int k = 0; k < 13; k++) begin
                if (iv[k]) begin
                    pv = mulq32(pv, pw[k]);
                end
            end
            num    = ONE - pv;
            den    = ONE + pv;
            tab[i] = 24'(udiv((num << 23) + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam tab_t TAB = build_tab();

    logic [23:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= TAB[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire
